FILE: src/first_fit_chunk_allocator_macros.svh
// Assertion macros shared by the allocator modules.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_MACROS_SVH
// Implication checked at every edge outside reset.
`define FFCA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FFCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: src/ffca_pkg.sv
// Package with the allocator's constants, codes and control types.
package ffca_pkg;
  localparam int TABLE_DEPTH = 64;
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_BITS = 32;
  localparam int SIZE_BITS = 24;
  localparam int TIDX_BITS = $clog2(TABLE_DEPTH);
  localparam int TCNT_BITS = $clog2(TABLE_DEPTH + 1);
  localparam int SIDX_BITS = $clog2(STACK_DEPTH);
  localparam int SCNT_BITS = $clog2(STACK_DEPTH + 1);
  localparam int ORDER_BITS = 16;
  localparam int REQ_BITS = 24;
  localparam int OUT_ADDR_BITS = 32;
  localparam int CFG_BITS = 32;
  localparam int META_BITS = 8;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_POP = 2'd1;

  localparam logic [1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [1:0] REG_HEAP_LIMIT = 2'd1;
  localparam logic [1:0] REG_METADATA = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_STACK_EMPTY = 3'd1;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
  localparam logic [2:0] ST_HEAP_FULL = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL = 3'd4;
  localparam logic [2:0] ST_STACK_FULL = 3'd5;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic pop_read;
    logic commit;
  } ffca_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_pop;
    logic scan_done;
  } ffca_sts_t;

  function automatic logic [SIZE_BITS-1:0] class_of(input logic [REQ_BITS-1:0] req);
    logic [SIZE_BITS-1:0] r;
    r = SIZE_BITS'(req);
    if (req <= REQ_BITS'(32)) r = SIZE_BITS'(32);
    else if (req <= REQ_BITS'(64)) r = SIZE_BITS'(64);
    else if (req <= REQ_BITS'(128)) r = SIZE_BITS'(128);
    else if (req <= REQ_BITS'(256)) r = SIZE_BITS'(256);
    else if (req <= REQ_BITS'(512)) r = SIZE_BITS'(512);
    return r;
  endfunction
endpackage

FILE: src/ffca_if.sv
// Valid/ready channel interfaces for requests and results.
interface ffca_req_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [23:0] request_size;
  logic [31:0] free_address;
  modport source (output valid, action, request_size, free_address, input ready);
  modport sink (input valid, action, request_size, free_address, output ready);
endinterface

interface ffca_rsp_if;
  logic valid;
  logic ready;
  logic [31:0] address;
  logic [23:0] granted_size;
  logic reused;
  logic [2:0] status;
  modport source (output valid, address, granted_size, reused, status, input ready);
  modport sink (input valid, address, granted_size, reused, status, output ready);
endinterface

FILE: src/ffca_ctrl.sv
// Controller state machine sequencing table scans and result delivery.
`include "first_fit_chunk_allocator_macros.svh"
module ffca_ctrl
  import ffca_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ffca_sts_t sts,
  output ffca_cmd_t cmd
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DECODE = 6'b000010,
    S_POPRD = 6'b000100,
    S_SCAN = 6'b001000,
    S_COMMIT = 6'b010000,
    S_OUT = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_pop) begin
          cmd.pop_read = 1'b1;
          state_next = S_POPRD;
        end else begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_POPRD: begin
        cmd.scan_start = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `FFCA_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(state))
  `FFCA_ASSERT_NEXT(a_load_decode, clk, rst, cmd.load, state == S_DECODE)
  `FFCA_ASSERT_IMP(a_no_overlap, clk, rst, in_ready, !out_valid)
endmodule

FILE: src/ffca_dp.sv
// Datapath with the chunk table, address stack, heap top and result register.
`include "first_fit_chunk_allocator_macros.svh"
module ffca_dp
  import ffca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ffca_cmd_t             cmd,
  output ffca_sts_t             sts,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic [1:0]            in_action,
  input  logic [REQ_BITS-1:0]   in_size,
  input  logic [ADDR_BITS-1:0]  in_addr,
  output logic [OUT_ADDR_BITS-1:0] address,
  output logic [23:0]           granted_size,
  output logic                  reused,
  output logic [2:0]            status
);
  logic [ADDR_BITS-1:0] heap_limit, heap_top;
  logic [META_BITS-1:0] metadata_bytes;
  logic [TCNT_BITS-1:0] entry_count;
  logic [SCNT_BITS-1:0] lifo_count;
  logic [ORDER_BITS-1:0] free_order_counter;

  logic [ADDR_BITS-1:0] entry_address [TABLE_DEPTH];
  logic [SIZE_BITS-1:0] entry_size [TABLE_DEPTH];
  logic [ORDER_BITS-1:0] entry_free_order [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_is_free;
  logic [ADDR_BITS-1:0] lifo_address [STACK_DEPTH];

  logic [1:0] act;
  logic [SIZE_BITS-1:0] size;
  logic [ADDR_BITS-1:0] key;
  logic stack_bad;
  logic [TCNT_BITS-1:0] scan_idx;
  logic [TIDX_BITS-1:0] rd_idx;
  logic rd_valid;
  logic [ADDR_BITS-1:0] rd_addr;
  logic [SIZE_BITS-1:0] rd_size;
  logic [ORDER_BITS-1:0] rd_order;
  logic rd_free;
  logic found;
  logic [TIDX_BITS-1:0] best;
  logic [ORDER_BITS-1:0] best_age;
  logic [ADDR_BITS-1:0] best_addr;
  logic [ORDER_BITS-1:0] age;
  logic fit_hit, addr_hit;
  logic [ADDR_BITS:0] need, room;
  logic heap_ok;

  assign sts.is_alloc = (act == ACT_ALLOC);
  assign sts.is_pop = (act == ACT_POP);
  assign sts.scan_done = !rd_valid && (scan_idx >= entry_count || found && !sts.is_alloc);

  assign age = free_order_counter - rd_order;
  assign fit_hit = rd_valid && rd_free && rd_size >= size;
  assign addr_hit = rd_valid && !rd_free && rd_addr == key;
  assign need = (ADDR_BITS+1)'(size) + (ADDR_BITS+1)'(metadata_bytes);
  assign room = {1'b0, heap_limit} - {1'b0, heap_top};
  assign heap_ok = heap_top <= heap_limit && room >= need;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= in_action;
      size <= class_of(in_size);
      key <= in_addr;
    end
    if (cmd.pop_read) key <= lifo_address[SIDX_BITS'(lifo_count - SCNT_BITS'(1))];
    if (cmd.scan_step && !sts.scan_done && scan_idx < entry_count) begin
      rd_idx <= TIDX_BITS'(scan_idx);
      rd_addr <= entry_address[TIDX_BITS'(scan_idx)];
      rd_size <= entry_size[TIDX_BITS'(scan_idx)];
      rd_order <= entry_free_order[TIDX_BITS'(scan_idx)];
      rd_free <= entry_is_free[TIDX_BITS'(scan_idx)];
    end
    if (cmd.scan_step && ((sts.is_alloc && fit_hit && (!found || age > best_age)) ||
                          (!sts.is_alloc && addr_hit && !found))) begin
      best <= rd_idx;
      best_age <= age;
      best_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      found <= 1'b0;
      scan_idx <= '0;
      stack_bad <= 1'b0;
    end else begin
      if (cmd.load) stack_bad <= 1'b0;
      if (cmd.pop_read && lifo_count == '0) stack_bad <= 1'b1;
      if (cmd.scan_start) begin
        scan_idx <= '0;
        found <= 1'b0;
        rd_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_valid <= !sts.scan_done && scan_idx < entry_count;
        if (!sts.scan_done && scan_idx < entry_count) scan_idx <= scan_idx + TCNT_BITS'(1);
        if ((sts.is_alloc && fit_hit) || (!sts.is_alloc && addr_hit)) found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= '1;
      metadata_bytes <= META_BITS'(24);
      heap_top <= '0;
      entry_count <= '0;
      lifo_count <= '0;
      free_order_counter <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HEAP_BASE: begin
            if (entry_count == '0) heap_top <= cfg_data;
          end
          REG_HEAP_LIMIT: heap_limit <= cfg_data;
          REG_METADATA: metadata_bytes <= META_BITS'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.commit) begin
        address <= '0;
        granted_size <= '0;
        reused <= 1'b0;
        status <= ST_OK;
        if (sts.is_alloc) begin
          if (lifo_count >= SCNT_BITS'(STACK_DEPTH)) status <= ST_STACK_FULL;
          else if (found) begin
            entry_is_free[best] <= 1'b0;
            lifo_address[SIDX_BITS'(lifo_count)] <= best_addr;
            lifo_count <= lifo_count + SCNT_BITS'(1);
            address <= best_addr;
            granted_size <= size;
            reused <= 1'b1;
          end else if (entry_count >= TCNT_BITS'(TABLE_DEPTH)) status <= ST_TABLE_FULL;
          else if (!heap_ok) status <= ST_HEAP_FULL;
          else begin
            heap_top <= heap_top + ADDR_BITS'(need);
            entry_address[TIDX_BITS'(entry_count)] <= heap_top;
            entry_size[TIDX_BITS'(entry_count)] <= size;
            entry_is_free[TIDX_BITS'(entry_count)] <= 1'b0;
            entry_free_order[TIDX_BITS'(entry_count)] <= '0;
            entry_count <= entry_count + TCNT_BITS'(1);
            lifo_address[SIDX_BITS'(lifo_count)] <= heap_top;
            lifo_count <= lifo_count + SCNT_BITS'(1);
            address <= heap_top;
            granted_size <= size;
          end
        end else if (stack_bad) status <= ST_STACK_EMPTY;
        else begin
          if (sts.is_pop) lifo_count <= lifo_count - SCNT_BITS'(1);
          if (found) begin
            entry_is_free[best] <= 1'b1;
            entry_free_order[best] <= free_order_counter;
            free_order_counter <= free_order_counter + ORDER_BITS'(1);
            address <= best_addr;
          end else status <= ST_NOT_ALLOC;
        end
      end
    end
  end

  `FFCA_ASSERT_IMP(a_cnt, clk, rst, 1'b1, entry_count <= TCNT_BITS'(TABLE_DEPTH))
  `FFCA_ASSERT_IMP(a_stk, clk, rst, 1'b1, lifo_count <= SCNT_BITS'(STACK_DEPTH))
  `FFCA_ASSERT_NEXT(a_start, clk, rst, cmd.scan_start, !found && !rd_valid)
endmodule

FILE: src/first_fit_chunk_allocator.sv
// First-fit chunk allocator: it reuses the fitting free entry freed longest ago,
// found by a table walk that reads one entry per cycle, with a stack read first for
// a free of the most recent allocation; the registered result beat is held for as
// long as it is not taken, and no new request is accepted until it is taken.
module first_fit_chunk_allocator
  import ffca_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ffca_req_if.sink   req,
  ffca_rsp_if.source rsp,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);
  ffca_cmd_t cmd;
  ffca_sts_t sts;

  ffca_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready),
    .sts, .cmd
  );

  ffca_dp u_dp (
    .clk, .rst, .cmd, .sts,
    .cfg_we, .cfg_index, .cfg_data,
    .in_action(req.action), .in_size(req.request_size), .in_addr(req.free_address),
    .address(rsp.address), .granted_size(rsp.granted_size),
    .reused(rsp.reused), .status(rsp.status)
  );
endmodule

FILE: dv/tb_pkg.sv
`timescale 1ns / 1ps
// Testbench package with the action codes that the package does not name.
package tb_pkg;
  localparam logic [1:0] ACT_FREE_ADDR = 2'd2;
  localparam logic [1:0] ACT_FREE_ALIAS = 2'd3;
endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the first-fit chunk allocator, checked beat by beat against its own predictor.
module tb_top;
  import ffca_pkg::*;
  import tb_pkg::*;

  typedef struct packed {
    logic [31:0] address;
    logic [23:0] granted_size;
    logic reused;
    logic [2:0] status;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_HEAP_BASE;
  logic [31:0] cfg_data = '0;

  ffca_req_if req ();
  ffca_rsp_if rsp ();

  first_fit_chunk_allocator DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [31:0] limit_reg, top_reg;
  logic [7:0] meta_reg;
  int unsigned n_entries, n_stack;
  logic [31:0] chunk_addr [TABLE_DEPTH];
  logic [23:0] chunk_len [TABLE_DEPTH];
  logic chunk_free [TABLE_DEPTH];
  logic [15:0] chunk_order [TABLE_DEPTH];
  logic [15:0] order_ctr;
  logic [31:0] grant_stack [STACK_DEPTH];
  grant_t pending_grants [$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  initial begin
    req.valid = 1'b0;
    req.action = ACT_ALLOC;
    req.request_size = '0;
    req.free_address = '0;
    rsp.ready = 1'b0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("error at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [23:0] round_size(input logic [23:0] r);
    if (r > 24'd512) return r;
    if (r <= 24'd32) return 24'd32;
    if (r <= 24'd64) return 24'd64;
    if (r <= 24'd128) return 24'd128;
    if (r <= 24'd256) return 24'd256;
    return 24'd512;
  endfunction

  function automatic bit mark_free(input logic [31:0] a);
    for (int i = 0; i < n_entries; i++) begin
      if (!chunk_free[i] && chunk_addr[i] == a) begin
        chunk_free[i] = 1'b1;
        chunk_order[i] = order_ctr;
        order_ctr++;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic grant_t predict_grant(input logic [1:0] act, input logic [23:0] rq,
                                           input logic [31:0] fa);
    grant_t g;
    logic [23:0] sz;
    logic [15:0] age, best_age;
    logic [32:0] need;
    int best;
    logic [31:0] a;
    g = '0;
    if (act == ACT_ALLOC) begin
      sz = round_size(rq);
      best = -1;
      best_age = '0;
      if (n_stack >= STACK_DEPTH) begin
        g.status = ST_STACK_FULL;
        return g;
      end
      for (int i = 0; i < n_entries; i++) begin
        if (chunk_free[i] && chunk_len[i] >= sz) begin
          age = order_ctr - chunk_order[i];
          if (best < 0 || age > best_age) begin
            best = i;
            best_age = age;
          end
        end
      end
      if (best >= 0) begin
        chunk_free[best] = 1'b0;
        grant_stack[n_stack++] = chunk_addr[best];
        g.address = chunk_addr[best];
        g.granted_size = sz;
        g.reused = 1'b1;
        g.status = ST_OK;
        return g;
      end
      if (n_entries >= TABLE_DEPTH) begin
        g.status = ST_TABLE_FULL;
        return g;
      end
      need = {9'd0, sz} + {25'd0, meta_reg};
      if (top_reg > limit_reg || {1'b0, limit_reg - top_reg} < need) begin
        g.status = ST_HEAP_FULL;
        return g;
      end
      chunk_addr[n_entries] = top_reg;
      chunk_len[n_entries] = sz;
      chunk_free[n_entries] = 1'b0;
      chunk_order[n_entries] = '0;
      n_entries++;
      grant_stack[n_stack++] = top_reg;
      g.address = top_reg;
      g.granted_size = sz;
      g.status = ST_OK;
      top_reg = top_reg + need[31:0];
      return g;
    end
    if (act == ACT_POP) begin
      if (n_stack == 0) begin
        g.status = ST_STACK_EMPTY;
        return g;
      end
      n_stack--;
      a = grant_stack[n_stack];
    end else begin
      a = fa;
    end
    if (mark_free(a)) begin
      g.address = a;
      g.status = ST_OK;
    end else begin
      g.status = ST_NOT_ALLOC;
    end
    return g;
  endfunction

  task automatic idle_burst();
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic send_beat(input logic [1:0] act, input logic [23:0] rq, input logic [31:0] fa);
    grant_t g;
    if (!quiet && $urandom_range(0, 5) == 0) idle_burst();
    req.valid = 1'b1;
    req.action = act;
    req.request_size = rq;
    req.free_address = fa;
    g = predict_grant(act, rq, fa);
    pending_grants.insert(pending_grants.size(), g);
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) begin
      if (n_entries == 0) top_reg = v;
    end else if (idx == REG_HEAP_LIMIT) begin
      limit_reg = v;
    end else begin
      meta_reg = v[7:0];
    end
  endtask

  function automatic logic [31:0] known_address();
    if (n_entries == 0 || $urandom_range(0, 3) == 0) return $urandom;
    return chunk_addr[$urandom_range(0, n_entries - 1)];
  endfunction

  function automatic logic [23:0] random_size();
    case ($urandom_range(0, 9))
      0: return 24'($urandom);
      1, 2: return 24'($urandom_range(513, 4096));
      default: return 24'($urandom_range(0, 512));
    endcase
  endfunction

  // Stall the result side in bursts, with long runs of no stall.
  always @(negedge clk) begin
    if (!rst && !quiet && rsp.ready && $urandom_range(0, 7) == 0) begin
      rsp.ready <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    rsp.ready <= 1'b1;
  end

  always @(posedge clk) begin
    grant_t want;
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_grants.size() == 0) begin
        report("unexpected beat, status", 64'(rsp.status), '0);
      end else begin
        want = pending_grants.pop_front();
        if (rsp.address !== want.address)
          report("address", 64'(rsp.address), 64'(want.address));
        if (rsp.granted_size !== want.granted_size)
          report("granted_size", 64'(rsp.granted_size), 64'(want.granted_size));
        if (rsp.reused !== want.reused)
          report("reused", 64'(rsp.reused), 64'(want.reused));
        if (rsp.status !== want.status)
          report("status", 64'(rsp.status), 64'(want.status));
      end
    end
    if (cycles > 2000000) begin
      $display("first_fit_chunk_allocator: mismatch");
      $finish;
    end
  end

  task automatic test_directed();
    logic [23:0] edge_sizes [9] = '{24'd0, 24'd1, 24'd32, 24'd33, 24'd64, 24'd256,
                                    24'd512, 24'd513, 24'hFFFFFF};
    send_beat(ACT_POP, 24'd0, 32'd0);
    send_beat(ACT_FREE_ADDR, 24'd0, 32'hFFFFFFFF);
    foreach (edge_sizes[i]) send_beat(ACT_ALLOC, edge_sizes[i], 32'd0);
    send_beat(ACT_POP, 24'd0, 32'd0);
    send_beat(ACT_FREE_ALIAS, 24'd0, chunk_addr[0]);
    send_beat(ACT_FREE_ADDR, 24'd0, chunk_addr[2]);
    send_beat(ACT_FREE_ADDR, 24'd0, chunk_addr[2]);
    send_beat(ACT_ALLOC, 24'd20, 32'd0);
    send_beat(ACT_POP, 24'd0, 32'd0);
    send_beat(ACT_POP, 24'd0, 32'd0);
  endtask

  task automatic test_config_limits();
    write_reg(REG_HEAP_LIMIT, top_reg + 32'd100);
    write_reg(REG_METADATA, 32'd255);
    send_beat(ACT_ALLOC, 24'd32, 32'd0);
    write_reg(REG_METADATA, 32'd0);
    send_beat(ACT_ALLOC, 24'd64, 32'd0);
    write_reg(REG_HEAP_LIMIT, 32'd0);
    send_beat(ACT_ALLOC, 24'd512, 32'd0);
    write_reg(REG_HEAP_BASE, 32'hFFFF_0000);
    write_reg(REG_HEAP_LIMIT, 32'hFFFFFFFF);
    write_reg(REG_METADATA, 32'd24);
  endtask

  task automatic test_stack_and_table_full();
    repeat (70) send_beat(ACT_ALLOC, 24'($urandom_range(600, 900)), 32'd0);
    repeat (70) send_beat(ACT_POP, 24'd0, 32'd0);
    repeat (70) send_beat(ACT_ALLOC, 24'd1000, 32'd0);
    repeat (30) send_beat(ACT_FREE_ADDR, 24'd0, known_address());
  endtask

  task automatic test_random(input int n);
    logic [1:0] act;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) begin
        drain();
        write_reg(REG_METADATA, $urandom);
      end
      if (k == n - 200) quiet = 1'b1;
      act = (n_stack > 48) ? 2'($urandom_range(1, 3)) : 2'($urandom_range(0, 3));
      if ($urandom_range(0, 2) == 0) act = ACT_ALLOC;
      send_beat(act, random_size(), known_address());
    end
  endtask

  initial begin
    limit_reg = 32'hFFFFFFFF;
    meta_reg = 8'd24;
    top_reg = '0;
    n_entries = 0;
    n_stack = 0;
    order_ctr = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    write_reg(REG_HEAP_BASE, 32'h0000_1000);
    test_directed();
    test_config_limits();
    test_stack_and_table_full();
    test_random(1700);
    drain();
    if (errors == 0) begin
      $display("first_fit_chunk_allocator: match");
    end else begin
      $display("first_fit_chunk_allocator: mismatch");
    end
    $finish;
  end
endmodule
